### hdl/rc4_stream_decrypt_top_macros.svh
// Assertion macros shared by the RC4 stream decryptor modules.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef RC4_STREAM_DECRYPT_TOP_MACROS_SVH
`define RC4_STREAM_DECRYPT_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RC4SD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RC4SD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/rc4sd_pkg.sv
// Shared types and constants for the RC4 stream decryptor.
// No dependencies; rc4sd_dp, rc4sd_ctrl and the top module import this package.
`timescale 1ns / 1ps

package rc4sd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PERM_DEPTH = 256;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned KEY_WORD_W = 64;
  localparam int unsigned KPOS_W     = 4;

  // Key lengths in bytes, written as the last key position used.
  localparam logic [KPOS_W-1:0] KPOS_LAST_40  = 4'd4;
  localparam logic [KPOS_W-1:0] KPOS_LAST_128 = 4'd15;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_HIGH = 2'd2;

  localparam logic KEY_MODE_40  = 1'b0;
  localparam logic KEY_MODE_128 = 1'b1;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KRDK,
    ST_KRDJ,
    ST_KWRK,
    ST_KWRJ,
    ST_PRDI,
    ST_PRDJ,
    ST_PWRI,
    ST_PWRJ,
    ST_PRDK,
    ST_OUT
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_IN,
    OP_FILL,
    OP_KSA_RD_K,
    OP_KSA_RD_J,
    OP_KSA_WR_K,
    OP_KSA_WR_J,
    OP_PRGA_RD_I,
    OP_PRGA_RD_J,
    OP_PRGA_WR_I,
    OP_PRGA_WR_J,
    OP_PRGA_RD_K,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic k_max;     // schedule counter at its last entry
    logic last;      // held word is the last of its message
    logic out_free;  // output register can take a word this cycle
  } dp_status_t;

endpackage

### hdl/rc4sd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the RC4 permutation table.
`timescale 1ns / 1ps

module rc4sd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/rc4sd_dp.sv
// Datapath of the RC4 stream decryptor: key registers, indices, permutation RAM, output word.
// Depends on rc4sd_pkg and rc4sd_ram; driven by rc4sd_ctrl through a command struct.
`timescale 1ns / 1ps
`include "rc4_stream_decrypt_top_macros.svh"

module rc4sd_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rc4sd_pkg::dp_cmd_t             cmd,
  output rc4sd_pkg::dp_status_t          sts,
  input  logic [7:0]                     in_tdata,
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  input  logic [rc4sd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data
);

  import rc4sd_pkg::*;

  logic                  key_mode_r;
  logic [KEY_WORD_W-1:0] key_low_r;
  logic [KEY_WORD_W-1:0] key_high_r;

  byte_t             i_r, i_nxt;
  byte_t             j_r, j_nxt;
  byte_t             k_r, k_nxt;
  logic [KPOS_W-1:0] kpos_r, kpos_nxt;
  byte_t             t_r, t_nxt;
  byte_t             u_r, u_nxt;
  byte_t             c_r;
  logic              last_r;
  logic              out_valid_r, out_valid_nxt;
  byte_t             out_data_r;
  logic              out_last_r;

  logic              ram_we, ram_re;
  byte_t             ram_waddr, ram_wdata, ram_raddr, ram_rdata;
  logic [2*KEY_WORD_W-1:0] key_all;
  byte_t             key_byte;
  logic [KPOS_W-1:0] kpos_last;

  assign key_all   = {key_high_r, key_low_r};
  assign key_byte  = key_all[{kpos_r, 3'b000} +: BYTE_W];
  assign kpos_last = (key_mode_r == KEY_MODE_128) ? KPOS_LAST_128 : KPOS_LAST_40;

  // Configuration registers; out-of-range indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_mode_r <= 1'b0;
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KEY_MODE:      key_mode_r <= cfg_data[0];
        REG_KEY_WORD_LOW:  key_low_r  <= cfg_data;
        REG_KEY_WORD_HIGH: key_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    kpos_nxt      = kpos_r;
    t_nxt         = t_r;
    u_nxt         = u_r;
    ram_we        = 1'b0;
    ram_waddr     = k_r;
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = k_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (cmd.op)
      OP_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = k_r;
        ram_wdata = k_r;
        k_nxt     = k_r + 8'd1;
        kpos_nxt  = '0;
        j_nxt     = '0;
      end
      OP_KSA_RD_K: begin
        ram_re    = 1'b1;
        ram_raddr = k_r;
      end
      OP_KSA_RD_J: begin
        t_nxt     = ram_rdata;
        j_nxt     = j_r + ram_rdata + key_byte;
        ram_re    = 1'b1;
        ram_raddr = j_nxt;
      end
      OP_KSA_WR_K: begin
        ram_we    = 1'b1;
        ram_waddr = k_r;
        ram_wdata = ram_rdata;
      end
      OP_KSA_WR_J: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = t_r;
        k_nxt     = k_r + 8'd1;
        kpos_nxt  = (kpos_r == kpos_last) ? '0 : kpos_r + 4'd1;
        // The keystream phase starts with both indices at zero.
        if (k_r == 8'hFF) begin
          i_nxt = '0;
          j_nxt = '0;
        end
      end
      OP_PRGA_RD_I: begin
        i_nxt     = i_r + 8'd1;
        ram_re    = 1'b1;
        ram_raddr = i_nxt;
      end
      OP_PRGA_RD_J: begin
        t_nxt     = ram_rdata;
        j_nxt     = j_r + ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = j_nxt;
      end
      OP_PRGA_WR_I: begin
        u_nxt     = ram_rdata;
        ram_we    = 1'b1;
        ram_waddr = i_r;
        ram_wdata = ram_rdata;
      end
      OP_PRGA_WR_J: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = t_r;
      end
      OP_PRGA_RD_K: begin
        ram_re    = 1'b1;
        ram_raddr = t_r + u_r;
      end
      OP_OUT: begin
        out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      kpos_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      kpos_r      <= kpos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r <= t_nxt;
    u_r <= u_nxt;
    if (cmd.op == OP_LOAD_IN) begin
      c_r    <= in_tdata;
      last_r <= in_tlast;
    end
    if (cmd.op == OP_OUT) begin
      out_data_r <= c_r ^ ram_rdata;
      out_last_r <= last_r;
    end
  end

  rc4sd_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(PERM_DEPTH)
  ) u_perm_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign sts.k_max    = (k_r == 8'hFF);
  assign sts.last     = last_r;
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `RC4SD_ASSERT_NOW(a_out_load_free, cmd.op == OP_OUT, !out_valid_r || out_tready, "output word overwritten while still pending")
  `RC4SD_ASSERT_NEXT(a_ksa_end_clear, cmd.op == OP_KSA_WR_J && k_r == 8'hFF, i_r == 8'd0 && j_r == 8'd0, "indices not cleared at end of key schedule")
  `RC4SD_ASSERT_NEXT(a_fill_clear, cmd.op == OP_FILL, kpos_r == 4'd0 && j_r == 8'd0, "key position or j not cleared during table fill")

endmodule

### hdl/rc4sd_ctrl.sv
// Sequencer of the RC4 stream decryptor: table fill, key schedule and keystream steps.
// Depends on rc4sd_pkg; issues one datapath command per cycle to rc4sd_dp.
`timescale 1ns / 1ps
`include "rc4_stream_decrypt_top_macros.svh"

module rc4sd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output rc4sd_pkg::dp_cmd_t    cmd,
  input  rc4sd_pkg::dp_status_t sts
);

  import rc4sd_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        need_sched_r, need_sched_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      need_sched_r <= 1'b1;
    end else begin
      state_r      <= state_nxt;
      need_sched_r <= need_sched_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    need_sched_nxt = need_sched_r;
    cmd.op         = OP_NONE;
    in_tready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = OP_LOAD_IN;
          state_nxt = need_sched_r ? ST_FILL : ST_PRDI;
        end
      end
      ST_FILL: begin
        cmd.op = OP_FILL;
        // The counter wraps back to zero, ready for the schedule proper.
        if (sts.k_max) begin
          state_nxt = ST_KRDK;
        end
      end
      ST_KRDK: begin
        cmd.op    = OP_KSA_RD_K;
        state_nxt = ST_KRDJ;
      end
      ST_KRDJ: begin
        cmd.op    = OP_KSA_RD_J;
        state_nxt = ST_KWRK;
      end
      ST_KWRK: begin
        cmd.op    = OP_KSA_WR_K;
        state_nxt = ST_KWRJ;
      end
      ST_KWRJ: begin
        cmd.op = OP_KSA_WR_J;
        if (sts.k_max) begin
          need_sched_nxt = 1'b0;
          state_nxt      = ST_PRDI;
        end else begin
          state_nxt = ST_KRDK;
        end
      end
      ST_PRDI: begin
        cmd.op    = OP_PRGA_RD_I;
        state_nxt = ST_PRDJ;
      end
      ST_PRDJ: begin
        cmd.op    = OP_PRGA_RD_J;
        state_nxt = ST_PWRI;
      end
      ST_PWRI: begin
        cmd.op    = OP_PRGA_WR_I;
        state_nxt = ST_PWRJ;
      end
      ST_PWRJ: begin
        cmd.op    = OP_PRGA_WR_J;
        state_nxt = ST_PRDK;
      end
      ST_PRDK: begin
        cmd.op    = OP_PRGA_RD_K;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.op         = OP_OUT;
          need_sched_nxt = sts.last;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `RC4SD_ASSERT_NEXT(a_sched_start, in_tvalid && in_tready && need_sched_r, state_r == ST_FILL, "first word of a message did not start the key schedule")
  `RC4SD_ASSERT_NEXT(a_sched_done, state_r == ST_KWRJ && sts.k_max, state_r == ST_PRDI && !need_sched_r, "key schedule did not hand over to keystream")
  `RC4SD_ASSERT_NEXT(a_out_rekey, state_r == ST_OUT && sts.out_free, state_r == ST_IDLE && need_sched_r == $past(sts.last), "rekey flag does not follow the last marker")

endmodule

### hdl/rc4_stream_decrypt_top.sv
// RC4 stream decryptor: a byte comes in on in_, a plain byte leaves on out_, cfg_ sets
// the key. Each accepted byte passes an accept step and six steps on the single-port-write
// permutation RAM: read i, read j, write i, write j, read keystream and load output, the
// last waiting while the output register is still full. The first byte after reset and
// the first byte after a byte with tlast wait first for a refill of all 256 table entries
// with the identity and for 256 key-schedule steps of a read of k, a read of j, a write
// of k and a write of j. The key registers are read during that schedule, so key writes
// made in mid-message apply to the next message. The finished byte sits in an output
// register, and the next byte is accepted while it waits. Configuration is always ready;
// writes to index 3 are ignored. Depends on rc4sd_pkg, rc4sd_ctrl, rc4sd_dp and rc4sd_ram.
`timescale 1ns / 1ps

module rc4_stream_decrypt_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] cipher_byte
  input  logic                            in_tlast,   // last_byte
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // [7:0] plain_byte
  output logic                            out_tlast,  // last_out
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rc4sd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                     cfg_data
);

  import rc4sd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;

  assign cfg_ready = 1'b1;

  rc4sd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  rc4sd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
